// ===== rtl/rfd_pkg.sv =====
// Shared types and constants for the referee frame deframer.
package rfd_pkg;

    localparam logic [7:0]  SOF_BYTE      = 8'hA5;
    localparam logic [15:0] CMD_GAME_TIME = 16'h0001;
    localparam logic [15:0] CMD_ROBOT_HP  = 16'h0201;
    localparam logic [15:0] CMD_SHOOT     = 16'h0207;
    localparam logic [15:0] CMD_HURT      = 16'h0206;
    localparam logic [7:0]  STAGE_MASK    = 8'hF0;
    localparam logic [7:0]  STAGE_IDLE    = 8'h40;
    localparam logic [7:0]  ARMOR_MASK    = 8'h0F;

    localparam int          HEADER_LEN    = 6;
    localparam int          KEEP_BYTES    = 4;
    localparam int          QUEUE_DEPTH   = 3;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HEAD = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_TIME   = 2'd0,
        KIND_HP     = 2'd1,
        KIND_SHOTS  = 2'd2,
        KIND_ATTACK = 2'd3
    } t_kind;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [15:0] value;
    } t_result;

endpackage

// ===== rtl/rfd_parser.sv =====
// Frame parser: header capture, payload counting and end-of-frame decode.
module rfd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    output rfd_pkg::t_result o_result
);
    import rfd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [16:0] r_cnt, n_cnt;
    logic [15:0] r_len, n_len;
    logic [15:0] r_cmd, n_cmd;
    logic [7:0]  r_head [KEEP_BYTES];
    logic [7:0]  n_head [KEEP_BYTES];
    logic [15:0] r_shot, n_shot;

    logic [16:0] cnt_inc;
    logic        body_done;
    logic [7:0]  eff [KEEP_BYTES];
    t_result     res;

    assign cnt_inc   = r_cnt + 17'd1;
    assign body_done = {1'b0, cnt_inc} >= ({2'b00, r_len} + 18'd2);

    // Current byte counts as kept payload when it lands in the first four.
    always_comb begin
        for (int i = 0; i < KEEP_BYTES; i++) begin
            eff[i] = (r_cnt == 17'(i)) ? i_byte : r_head[i];
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_len   = r_len;
        n_cmd   = r_cmd;
        n_shot  = r_shot;
        n_head  = r_head;
        res     = '0;
        if (i_valid) begin
            case (r_phase)
                PH_HEAD: begin
                    case (r_cnt[2:0])
                        3'd0:    n_len[7:0]  = i_byte;
                        3'd1:    n_len[15:8] = i_byte;
                        3'd4:    n_cmd[7:0]  = i_byte;
                        3'd5:    n_cmd[15:8] = i_byte;
                        default: ;
                    endcase
                    if (r_cnt >= 17'(HEADER_LEN - 1)) begin
                        n_cnt   = '0;
                        n_phase = PH_BODY;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                PH_BODY: begin
                    n_head = eff;
                    n_cnt  = cnt_inc;
                    if (body_done) begin
                        n_cnt   = '0;
                        n_phase = PH_HUNT;
                        case (r_cmd)
                            CMD_GAME_TIME: begin
                                res.valid = 1'b1;
                                res.kind  = KIND_TIME;
                                res.value = ((eff[0] & STAGE_MASK) == STAGE_IDLE) ?
                                            16'd0 : {eff[2], eff[1]};
                            end
                            CMD_ROBOT_HP: begin
                                res.valid = 1'b1;
                                res.kind  = KIND_HP;
                                res.value = {eff[3], eff[2]};
                            end
                            CMD_SHOOT: begin
                                if (r_shot != 16'hFFFF) begin
                                    n_shot = r_shot + 16'd1;
                                end
                                res.valid = 1'b1;
                                res.kind  = KIND_SHOTS;
                                res.value = n_shot;
                            end
                            CMD_HURT: begin
                                res.kind  = KIND_ATTACK;
                                res.value = {8'h00, eff[0] & ARMOR_MASK};
                                res.valid = (res.value != 16'd0);
                            end
                            default: ;
                        endcase
                    end
                end
                default: begin
                    // Hunt: drop everything until a start byte.
                    n_phase = PH_HUNT;
                    if (i_byte == SOF_BYTE) begin
                        n_phase = PH_HEAD;
                        n_cnt   = '0;
                        n_len   = '0;
                        n_cmd   = '0;
                        for (int i = 0; i < KEEP_BYTES; i++) begin
                            n_head[i] = '0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_cnt   <= '0;
            r_len   <= '0;
            r_cmd   <= '0;
            r_shot  <= '0;
            for (int i = 0; i < KEEP_BYTES; i++) begin
                r_head[i] <= '0;
            end
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_cmd   <= n_cmd;
            r_shot  <= n_shot;
            r_head  <= n_head;
        end
    end

    assign o_result = res;

`ifndef SYNTHESIS
    a_shot_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_shot >= $past(r_shot))
        else $error("shot count decreased");

    a_result_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |=> r_phase == PH_HUNT && r_cnt == 17'd0)
        else $error("result without return to hunt");

    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEAD |-> r_cnt < 17'(HEADER_LEN))
        else $error("header counter overran");
`endif

endmodule

// ===== rtl/referee_frame_deframer.sv =====
// Top level: input register, frame parser and three-entry result queue.
// A result is offered on o_m_tvalid once the byte that ends its frame has
// passed the input register and has been written into the result queue.
// Throughput: one byte per cycle while the sink takes results; the three-entry
// result queue sets how long the sink may stall before o_s_tready drops.
// Reset (i_rst_n low, synchronous) empties the queue and returns the parser to
// hunting for a start byte with all counters and the shot count at zero.
module referee_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] msg_value
    output logic [1:0]  o_m_tuser    // [1:0] msg_kind
);
    import rfd_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    t_result     res;

    t_result     r_q [QUEUE_DEPTH];
    logic [1:0]  r_wr, r_rd, r_count;
    logic [1:0]  n_count;
    logic        q_push, q_pop;
    logic [2:0]  used;

    // Count queued results plus the byte in flight so a result always has room.
    assign used       = {1'b0, r_count} + {2'b00, r_in_valid};
    assign o_s_tready = used < 3'(QUEUE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_s_tvalid && o_s_tready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    rfd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_byte   (r_in_byte),
        .o_result (res)
    );

    assign q_push  = r_in_valid && res.valid;
    assign q_pop   = (r_count != 2'd0) && i_m_tready;
    assign n_count = r_count + {1'b0, q_push} - {1'b0, q_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (q_push) begin
                r_wr <= (r_wr == 2'(QUEUE_DEPTH - 1)) ? 2'd0 : r_wr + 2'd1;
            end
            if (q_pop) begin
                r_rd <= (r_rd == 2'(QUEUE_DEPTH - 1)) ? 2'd0 : r_rd + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q[r_wr] <= res;
        end
    end

    assign o_m_tvalid = r_count != 2'd0;
    assign o_m_tdata  = r_q[r_rd].value;
    assign o_m_tuser  = r_q[r_rd].kind;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> r_count < 2'(QUEUE_DEPTH))
        else $error("result pushed into a full queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push && !q_pop |=> r_count == $past(r_count) + 2'd1)
        else $error("queue count lost a push");
`endif

endmodule

// ===== tb/rfd_msg_checker.sv =====
// Checker for the referee frame deframer: predicts decoded messages and compares transfers.
module rfd_msg_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [15:0] msg_value
    input  logic [1:0]  i_m_tuser,   // [1:0] msg_kind
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    import rfd_pkg::*;

    localparam logic [16:0] LEN_LO_AT   = 17'd0;
    localparam logic [16:0] LEN_HI_AT   = 17'd1;
    localparam logic [16:0] CMD_LO_AT   = 17'd4;
    localparam logic [16:0] CMD_HI_AT   = 17'd5;
    localparam int          MAX_REPORTS = 10;

    typedef struct {
        t_kind       kind;
        logic [15:0] value;
    } t_msg;

    t_phase      phase;
    logic [16:0] byte_cnt;
    logic [15:0] frame_len;
    logic [15:0] cmd_id;
    logic [7:0]  kept [KEEP_BYTES];
    logic [15:0] shots;
    t_msg        expected_msgs [$];
    int          fails   = 0;
    int          checked = 0;
    int          pending = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;
    assign o_checked    = checked;

    // Advance the frame parser by one byte; queue the decoded message at frame end.
    task automatic parse_rx_byte(input logic [7:0] b);
        t_msg        m;
        logic [15:0] armor;
        case (phase)
            PH_HEAD: begin
                case (byte_cnt)
                    LEN_LO_AT: frame_len[7:0]  = b;
                    LEN_HI_AT: frame_len[15:8] = b;
                    CMD_LO_AT: cmd_id[7:0]     = b;
                    CMD_HI_AT: cmd_id[15:8]    = b;
                    default: ;
                endcase
                byte_cnt = byte_cnt + 17'd1;
                if (byte_cnt >= HEADER_LEN) begin
                    byte_cnt = '0;
                    phase    = PH_BODY;
                end
            end
            PH_BODY: begin
                if (byte_cnt < KEEP_BYTES)
                    kept[byte_cnt[1:0]] = b;
                byte_cnt = byte_cnt + 17'd1;
                if (byte_cnt >= {1'b0, frame_len} + 17'd2) begin
                    byte_cnt = '0;
                    phase    = PH_HUNT;
                    armor    = {8'h00, kept[0] & ARMOR_MASK};
                    case (cmd_id)
                        CMD_GAME_TIME: begin
                            m.kind  = KIND_TIME;
                            m.value = ((kept[0] & STAGE_MASK) == STAGE_IDLE) ?
                                      16'h0000 : {kept[2], kept[1]};
                            expected_msgs.insert(expected_msgs.size(), m);
                        end
                        CMD_ROBOT_HP: begin
                            m.kind  = KIND_HP;
                            m.value = {kept[3], kept[2]};
                            expected_msgs.insert(expected_msgs.size(), m);
                        end
                        CMD_SHOOT: begin
                            if (shots != 16'hFFFF)
                                shots = shots + 16'd1;
                            m.kind  = KIND_SHOTS;
                            m.value = shots;
                            expected_msgs.insert(expected_msgs.size(), m);
                        end
                        CMD_HURT: begin
                            if (armor != 16'h0000) begin
                                m.kind  = KIND_ATTACK;
                                m.value = armor;
                                expected_msgs.insert(expected_msgs.size(), m);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                // a start byte opens a fresh frame; anything else is dropped
                phase = PH_HUNT;
                if (b == SOF_BYTE) begin
                    phase     = PH_HEAD;
                    byte_cnt  = '0;
                    frame_len = '0;
                    cmd_id    = '0;
                    foreach (kept[i]) kept[i] = '0;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_msg m;
        if (!i_rst_n) begin
            phase     = PH_HUNT;
            byte_cnt  = '0;
            frame_len = '0;
            cmd_id    = '0;
            shots     = '0;
            foreach (kept[i]) kept[i] = '0;
            expected_msgs.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                parse_rx_byte(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (expected_msgs.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("unexpected message: kind %0d value 0x%04h",
                                 i_m_tuser, i_m_tdata);
                end else begin
                    m = expected_msgs.pop_front();
                    checked++;
                    if (m.kind !== i_m_tuser || m.value !== i_m_tdata) begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $display("msg %0d: exp kind %0d val 0x%04h, got kind %0d val 0x%04h",
                                     checked, m.kind, m.value, i_m_tuser, i_m_tdata);
                    end
                end
            end
        end
        pending = expected_msgs.size();
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the referee frame deframer: byte stimulus, sink pacing and verdict.
module tb;
    import rfd_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_BYTES = 1000;
    localparam int TAIL_FRAMES  = 12;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    int fail_count;
    int pending;
    int checked;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit sink_hold     = 1'b0;
    int stall_cycles  = 0;
    int frames_sent   = 0;
    int bytes_sent    = 0;

    referee_frame_deframer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    rfd_msg_checker msg_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge clk);
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Sink pacing: random stall bursts, plus one long hold on request.
    initial begin
        forever begin
            @(posedge clk);
            if (sink_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold = 1'b0;
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 99) < sink_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 13)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one byte, maybe after an idle burst; return at its transfer edge.
    task automatic put_byte(input logic [7:0] b);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // head holds the first four payload bytes, payload byte 0 in the low bits.
    task automatic send_frame(input logic [15:0] len, input logic [15:0] cmd,
                              input logic [31:0] head);
        int n;
        n = int'(len) + 2;
        put_byte(SOF_BYTE);
        put_byte(len[7:0]);
        put_byte(len[15:8]);
        put_byte(8'($urandom_range(0, 255)));
        put_byte(8'($urandom_range(0, 255)));
        put_byte(cmd[7:0]);
        put_byte(cmd[15:8]);
        for (int k = 0; k < n; k++)
            put_byte(k < KEEP_BYTES ? head[8*(k & 3) +: 8] : 8'($urandom_range(0, 255)));
        frames_sent++;
        bytes_sent += HEADER_LEN + 1 + n;
    endtask

    // Stop offering bytes until every predicted message has been taken.
    task automatic drain_results;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        int          start_bytes;
        int          frame_no;
        int          sel;
        int          pos;
        logic [15:0] len;
        logic [15:0] cmd;
        logic [31:0] head;
        logic [7:0]  junk;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h5A);
        send_frame(16'd2, CMD_GAME_TIME, 32'h00FF_FF3F);
        send_frame(16'd2, CMD_GAME_TIME, 32'h0012_344F);
        send_frame(16'd0, CMD_GAME_TIME, 32'hFFFF_34F0);
        send_frame(16'd2, CMD_ROBOT_HP,  32'hFFFF_0000);
        send_frame(16'd1, CMD_ROBOT_HP,  32'h0080_0000);
        send_frame(16'd0, CMD_ROBOT_HP,  32'hFFFF_FFFF);
        send_frame(16'd0, CMD_SHOOT,     32'h0000_0000);
        send_frame(16'd1, CMD_HURT,      32'h0000_00F0);
        send_frame(16'd0, CMD_HURT,      32'h0000_000F);
        send_frame(16'd3, 16'hFFFF,      32'hFFFF_FFFF);
        // start byte as ordinary data in the payload
        send_frame(16'h00A5 & 16'h0005, CMD_ROBOT_HP, {4{SOF_BYTE}});
        send_frame({8'h00, SOF_BYTE} & 16'h0007, CMD_GAME_TIME, {4{SOF_BYTE}});
        drain_results();

        // random frames with noise in between
        start_bytes = bytes_sent;
        frame_no    = 0;
        while (bytes_sent < start_bytes + RANDOM_BYTES) begin
            case ((frame_no / 20) % 4)
                0: begin src_idle_pct = 30; sink_idle_pct = 30; end
                1: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
                2: begin src_idle_pct = 60; sink_idle_pct = 10; end
                default: begin src_idle_pct = 10; sink_idle_pct = 60; end
            endcase
            if (frame_no == 30)
                sink_hold = 1'b1;
            if (frame_no % 37 == 36)
                drain_results();

            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 5)) begin
                    junk = 8'($urandom_range(0, 255));
                    if (junk == SOF_BYTE)
                        junk = ~SOF_BYTE;
                    put_byte(junk);
                end
            end

            sel = $urandom_range(0, 9);
            case (sel)
                0, 1: cmd = CMD_GAME_TIME;
                2, 3: cmd = CMD_ROBOT_HP;
                4, 5: cmd = CMD_SHOOT;
                6, 7: cmd = CMD_HURT;
                8: cmd = 16'($urandom_range(0, 65535));
                default: cmd = CMD_HURT ^ (16'h0001 << $urandom_range(0, 15));
            endcase

            sel = $urandom_range(0, 19);
            if (sel < 14)
                len = 16'($urandom_range(0, 6));
            else if (sel < 19)
                len = 16'($urandom_range(7, 40));
            else
                len = 16'($urandom_range(41, 255));

            head = $urandom;
            if ($urandom_range(0, 3) == 0)
                head[7:0] = (head[7:0] & ~STAGE_MASK) | STAGE_IDLE;
            if ($urandom_range(0, 3) == 0)
                head[7:0] = head[7:0] & ~ARMOR_MASK;
            if ($urandom_range(0, 7) == 0) begin
                pos = $urandom_range(0, 3);
                head[8*pos +: 8] = SOF_BYTE;
            end
            send_frame(len, cmd, head);
            frame_no++;
        end
        drain_results();

        // full-rate tail: short frames with no idling on either side
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        for (int t = 0; t < TAIL_FRAMES; t++) begin
            case ($urandom_range(0, 3))
                0: cmd = CMD_GAME_TIME;
                1: cmd = CMD_ROBOT_HP;
                2: cmd = CMD_SHOOT;
                default: cmd = CMD_HURT;
            endcase
            send_frame(16'($urandom_range(0, 4)), cmd, $urandom);
        end

        drain_results();
        repeat (20) @(posedge clk);

        $display("Sent %0d frames (%0d frame bytes), checked %0d decoded messages;",
                 frames_sent, bytes_sent, checked);
        $display("covered short payloads, stray start bytes, a long sink hold and a full-rate tail.");
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d messages never delivered", fail_count, pending);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rfd_pkg.sv
rtl/rfd_parser.sv
rtl/referee_frame_deframer.sv
tb/rfd_msg_checker.sv
tb/tb.sv
